FILE: rtl/rss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rss supervisor package
// shared types, operation codes and fixed point constants
// ----------------------------------------------------------------------------
package rss_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_RISK  = 2'd1;
    localparam logic [1:0] OP_MERGE = 2'd2;
    localparam logic [1:0] OP_END   = 2'd3;

    localparam logic [2:0] CFG_RESPONSE  = 3'd0;
    localparam logic [2:0] CFG_MAX_ACCEL = 3'd1;
    localparam logic [2:0] CFG_COMFORT   = 3'd2;
    localparam logic [2:0] CFG_LEAD      = 3'd3;
    localparam logic [2:0] CFG_TTC       = 3'd4;
    localparam logic [2:0] CFG_MTIME     = 3'd5;
    localparam logic [2:0] CFG_MPROB     = 3'd6;

    localparam logic [2:0] RSN_NONE  = 3'd0;
    localparam logic [2:0] RSN_GAP   = 3'd1;
    localparam logic [2:0] RSN_RSS   = 3'd2;
    localparam logic [2:0] RSN_CRIT  = 3'd3;
    localparam logic [2:0] RSN_MERGE = 3'd4;

    localparam logic [1:0] LVL_NONE  = 2'd0;
    localparam logic [1:0] LVL_VETO  = 2'd1;
    localparam logic [1:0] LVL_CLAMP = 2'd2;
    localparam logic [1:0] LVL_EMERG = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] host_speed;
        logic [15:0] lead_speed;
        logic [17:0] lead_gap;
        logic [15:0] planned_speed;
        logic        lane_change_request;
        logic        gap_accepted;
        logic [7:0]  gap_reason_code;
        logic        event_flag;
        logic [15:0] event_time;
        logic [8:0]  merge_probability;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        speed_command;
        logic signed [11:0] accel_command;
        logic [1:0]         action_level;
        logic               lane_veto;
        logic               clamp_active;
        logic               hard_brake;
        logic [2:0]         reason_code;
        logic [7:0]         veto_reason;
        logic [23:0]        safe_distance;
        logic [31:0]        veto_total;
        logic [31:0]        intervention_total;
    } out_item_t;

    typedef struct packed {
        logic [15:0] reaction_time;
        logic [15:0] max_accel;
        logic [15:0] comfort_brake;
        logic [15:0] lead_brake;
        logic [15:0] critical_ttc_limit;
        logic [15:0] merge_time_limit;
        logic [8:0]  merge_prob_limit;
    } cfg_t;

    // c * 2^f rounded half up, c given in tenths
    function automatic int fx_tenths(input int tenths, input int f);
        return ((tenths << f) + 5) / 10;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/rss_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rss channel interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface rss_in_if import rss_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rss_out_if import rss_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/rss_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rss divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rss_div
    import rss_pkg::*;
#(
    parameter int NW = 34,
    parameter int DW = 18
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [NW-1:0]      quo
);
    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [DW:0]   shifted;
    logic          fits;

    assign shifted = {r_reg[DW-1:0], q_reg[NW-1]};
    assign fits = shifted >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[NW-2:0], fits};
            r_reg <= fits ? (shifted - {1'b0, d_reg}) : shifted;
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;
endmodule
`default_nettype wire

FILE: rtl/rss_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rss front end
// accepts input transactions into a short queue
// ----------------------------------------------------------------------------
module rss_front
    import rss_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rss_in_if.sink    in_ch,
    input  wire logic pop,
    output logic      q_valid,
    output in_item_t  q_item
);
    logic [1:0] cnt_reg;
    logic       wp_reg;
    logic       rp_reg;
    in_item_t   mem [2];
    logic       push;

    assign in_ch.ready = cnt_reg != 2'd2;
    assign push = in_ch.valid && in_ch.ready;
    assign q_valid = cnt_reg != 2'd0;
    assign q_item = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= in_ch.data;
    end
endmodule
`default_nettype wire

FILE: rtl/rss_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rss back end
// frame sequencer, safe distance datapath and decision state
// ----------------------------------------------------------------------------
module rss_back
    import rss_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire logic     q_valid,
    input  wire in_item_t q_item,
    output logic          pop,
    rss_out_if.source     out_ch
);
    localparam int F = FRAC_BITS;
    localparam int RVW = 33 - F;
    localparam int PW = 2 * RVW;
    localparam int SW = PW + 1;
    localparam logic [15:0] FL = 16'(fx_tenths(1, F));
    localparam logic [16:0] ONE = 17'(1 << F);
    localparam logic [17:0] VETO_DEC = 18'(fx_tenths(12, F));
    localparam logic [17:0] SIX = 18'(6 << F);
    localparam logic [17:0] THREE = 18'(3 << F);
    localparam logic [17:0] FOUR = 18'(4 << F);
    localparam logic [SW-1:0] FOUR_D = SW'(4 << F);
    localparam int ACL = fx_tenths(20, F);
    localparam int AEM = fx_tenths(48, F);
    localparam int AMG = fx_tenths(28, F);
    localparam logic signed [11:0] A_CLAMP = (ACL > 2048) ? -12'sd2048 : 12'(-ACL);
    localparam logic signed [11:0] A_EMERG = (AEM > 2048) ? -12'sd2048 : 12'(-AEM);
    localparam logic signed [11:0] A_MERGE = (AMG > 2048) ? -12'sd2048 : 12'(-AMG);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M1   = 4'd1;
    localparam logic [3:0] S_M2   = 4'd2;
    localparam logic [3:0] S_M3   = 4'd3;
    localparam logic [3:0] S_M4   = 4'd4;
    localparam logic [3:0] S_D1   = 4'd5;
    localparam logic [3:0] S_D1W  = 4'd6;
    localparam logic [3:0] S_D2   = 4'd7;
    localparam logic [3:0] S_D2W  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [3:0]  state_reg;
    in_item_t    it_reg;
    logic [15:0] b_reg, lb_reg;
    logic [31:0] ta_reg;
    logic [31:0] vt_reg;
    logic [31:0] tt_reg;
    logic [47:0] att_reg;
    logic [RVW-1:0] rv_reg;
    logic [PW-1:0]  rvsq_reg;
    logic [31:0]    lsq_reg;
    logic [PW-1:0]  eb_reg;
    logic [PW-1:0]  rd_reg;

    logic [15:0] held_ego_reg, spd_reg, gap_rsn_reg;
    logic signed [11:0] acc_reg;
    logic [1:0]  lvl_reg;
    logic [2:0]  flags_reg, rsn_reg;
    logic [23:0] sd_reg;
    logic        closed_reg;
    logic [31:0] vcnt_reg, icnt_reg;
    logic        ov_reg;
    out_item_t   od_reg;

    logic          dv_start;
    logic [PW-1:0] dv_num;
    logic [16:0]   dv_den;
    logic          dv_done;
    logic [PW-1:0] dv_quo;

    rss_div #(.NW(PW), .DW(17)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (dv_num),
        .den   (dv_den),
        .done  (dv_done),
        .quo   (dv_quo)
    );

    assign dv_start = (state_reg == S_D1) || (state_reg == S_D2);
    assign dv_num = (state_reg == S_D1) ? rvsq_reg : PW'(lsq_reg);
    assign dv_den = (state_reg == S_D1) ? {b_reg, 1'b0} : {lb_reg, 1'b0};

    // final distance
    logic [SW-1:0] pos, dfin;
    logic [23:0]   dsat;
    assign pos = {1'b0, rd_reg} + {1'b0, eb_reg};
    assign dfin = (pos >= {1'b0, dv_quo} + FOUR_D) ? pos - {1'b0, dv_quo} : FOUR_D;
    assign dsat = (dfin > SW'(24'hFFFFFF)) ? 24'hFFFFFF : dfin[23:0];

    // begin-item and merge clamp values
    logic [17:0] ego_x, vfloor, lead_up;
    logic [15:0] vclamp, lclamp, mclamp, spd_b;
    logic        veto;
    logic [15:0] hold_x;
    assign ego_x = {2'b0, it_reg.host_speed};
    assign vfloor = (ego_x >= VETO_DEC + SIX) ? ego_x - VETO_DEC : SIX;
    assign vclamp = vfloor[15:0];
    assign lead_up = {2'b0, it_reg.lead_speed} + {1'b0, ONE >> 1};
    assign lclamp = (lead_up > 18'hFFFF) ? 16'hFFFF : lead_up[15:0];
    assign hold_x = held_ego_reg;
    logic [17:0] mf;
    assign mf = ({2'b0, hold_x} >= THREE + FOUR) ? {2'b0, hold_x} - THREE : FOUR;
    assign mclamp = mf[15:0];
    assign veto = it_reg.lane_change_request && !it_reg.gap_accepted;
    assign spd_b = (veto && vclamp < it_reg.planned_speed) ? vclamp : it_reg.planned_speed;

    logic emerg;
    assign emerg = flags_reg[2];

    always_comb
    begin
        pop = 1'b0;
        if (state_reg == S_IDLE && q_valid)
        begin
            if (q_item.operation == OP_END && !closed_reg)
                pop = !ov_reg || out_ch.ready;
            else
                pop = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            held_ego_reg <= '0;
            spd_reg      <= '0;
            acc_reg      <= '0;
            lvl_reg      <= LVL_NONE;
            flags_reg    <= '0;
            rsn_reg      <= RSN_NONE;
            gap_rsn_reg  <= '0;
            sd_reg       <= '0;
            closed_reg   <= 1'b0;
            vcnt_reg     <= '0;
            icnt_reg     <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ch.ready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        case (q_item.operation)
                            OP_BEGIN:
                                state_reg <= S_M1;
                            OP_RISK:
                            begin
                                if (!closed_reg && !emerg && q_item.event_flag
                                    && q_item.event_time < cfg.critical_ttc_limit)
                                begin
                                    flags_reg <= flags_reg | 3'b110;
                                    spd_reg   <= '0;
                                    acc_reg   <= A_EMERG;
                                    lvl_reg   <= LVL_EMERG;
                                    rsn_reg   <= RSN_CRIT;
                                    icnt_reg  <= icnt_reg + 1'b1;
                                end
                            end
                            OP_MERGE:
                            begin
                                if (!closed_reg && !emerg && q_item.event_flag
                                    && q_item.event_time < cfg.merge_time_limit
                                    && q_item.merge_probability > cfg.merge_prob_limit)
                                begin
                                    flags_reg <= flags_reg | 3'b010;
                                    if (mclamp < spd_reg)
                                        spd_reg <= mclamp;
                                    if (A_MERGE < acc_reg)
                                        acc_reg <= A_MERGE;
                                    if (lvl_reg < LVL_CLAMP)
                                        lvl_reg <= LVL_CLAMP;
                                    rsn_reg <= RSN_MERGE;
                                end
                            end
                            default:
                            begin
                                if (!closed_reg)
                                begin
                                    closed_reg <= 1'b1;
                                    ov_reg     <= 1'b1;
                                    od_reg.speed_command      <= spd_reg;
                                    od_reg.accel_command      <= acc_reg;
                                    od_reg.action_level       <= lvl_reg;
                                    od_reg.lane_veto          <= flags_reg[0];
                                    od_reg.clamp_active       <= flags_reg[1];
                                    od_reg.hard_brake         <= flags_reg[2];
                                    od_reg.reason_code        <= rsn_reg;
                                    od_reg.veto_reason        <= (rsn_reg == RSN_GAP)
                                                                 ? gap_rsn_reg[7:0] : 8'd0;
                                    od_reg.safe_distance      <= sd_reg;
                                    od_reg.veto_total         <= vcnt_reg;
                                    if (!emerg && lvl_reg != LVL_NONE)
                                    begin
                                        icnt_reg <= icnt_reg + 1'b1;
                                        od_reg.intervention_total <= icnt_reg + 1'b1;
                                    end
                                    else
                                        od_reg.intervention_total <= icnt_reg;
                                end
                            end
                        endcase
                    end
                end
                S_M1:    state_reg <= S_M2;
                S_M2:    state_reg <= S_M3;
                S_M3:    state_reg <= S_M4;
                S_M4:    state_reg <= S_D1;
                S_D1:    state_reg <= S_D1W;
                S_D1W:   if (dv_done) state_reg <= S_D2;
                S_D2:    state_reg <= S_D2W;
                S_D2W:   if (dv_done) state_reg <= S_FIN;
                S_FIN:
                begin
                    state_reg    <= S_IDLE;
                    held_ego_reg <= it_reg.host_speed;
                    gap_rsn_reg  <= {8'd0, it_reg.gap_reason_code};
                    closed_reg   <= 1'b0;
                    sd_reg       <= dsat;
                    if (veto)
                    begin
                        vcnt_reg <= vcnt_reg + 1'b1;
                        icnt_reg <= icnt_reg + 1'b1;
                    end
                    if ({6'd0, it_reg.lead_gap} < dsat)
                    begin
                        flags_reg <= {1'b0, 1'b1, veto};
                        spd_reg   <= (lclamp < spd_b) ? lclamp : spd_b;
                        acc_reg   <= A_CLAMP;
                        lvl_reg   <= LVL_CLAMP;
                        rsn_reg   <= RSN_RSS;
                    end
                    else
                    begin
                        flags_reg <= veto ? 3'b011 : 3'b000;
                        spd_reg   <= spd_b;
                        acc_reg   <= '0;
                        lvl_reg   <= veto ? LVL_VETO : LVL_NONE;
                        rsn_reg   <= veto ? RSN_GAP : RSN_NONE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath, multiplies registered across states S_M1 to S_M3
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && pop)
            it_reg <= q_item;
        case (state_reg)
            S_M1:
            begin
                b_reg  <= (cfg.comfort_brake < FL) ? FL : cfg.comfort_brake;
                lb_reg <= (cfg.lead_brake < FL) ? FL : cfg.lead_brake;
                ta_reg <= cfg.reaction_time * cfg.max_accel;
                vt_reg <= it_reg.host_speed * cfg.reaction_time;
                tt_reg <= cfg.reaction_time * cfg.reaction_time;
                lsq_reg <= it_reg.lead_speed * it_reg.lead_speed;
            end
            S_M2:
            begin
                rv_reg  <= RVW'(it_reg.host_speed) + RVW'(ta_reg >> F);
                att_reg <= cfg.max_accel * tt_reg;
            end
            S_M3:
            begin
                rvsq_reg <= rv_reg * rv_reg;
                rd_reg   <= PW'(vt_reg >> F) + PW'(att_reg >> (2 * F + 1));
            end
            S_D1W:
                if (dv_done) eb_reg <= dv_quo;
            default: ;
        endcase
    end

    assign out_ch.valid = ov_reg;
    assign out_ch.data  = od_reg;
endmodule
`default_nettype wire

FILE: rtl/rss_safety_supervisor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rss safety supervisor
// frame based rss distance check, lane veto and speed clamp decisions
// ----------------------------------------------------------------------------
// begin transaction: multiply states, then two serial divisions of 66 - 2 * FRAC_BITS
// quotient bits each, then a final decision state
// risk, merge and end transactions: idle state only, end waits on an unaccepted result
// a two entry queue decouples input acceptance from the back end
// reset: configuration registers to defaults, counters and frame state cleared
module rss_safety_supervisor
    import rss_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    rss_in_if.sink                    in_ch,
    rss_out_if.source                 out_ch,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    cfg_t     cfg_reg;
    logic     q_valid, pop;
    in_item_t q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reaction_time      <= 16'd154;
            cfg_reg.max_accel          <= 16'd461;
            cfg_reg.comfort_brake      <= 16'd1152;
            cfg_reg.lead_brake         <= 16'd1536;
            cfg_reg.critical_ttc_limit <= 16'd307;
            cfg_reg.merge_time_limit   <= 16'd358;
            cfg_reg.merge_prob_limit   <= 9'd115;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RESPONSE:  cfg_reg.reaction_time      <= cfg_data;
                CFG_MAX_ACCEL: cfg_reg.max_accel          <= cfg_data;
                CFG_COMFORT:   cfg_reg.comfort_brake      <= cfg_data;
                CFG_LEAD:      cfg_reg.lead_brake         <= cfg_data;
                CFG_TTC:       cfg_reg.critical_ttc_limit <= cfg_data;
                CFG_MTIME:     cfg_reg.merge_time_limit   <= cfg_data;
                CFG_MPROB:     cfg_reg.merge_prob_limit   <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    rss_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .pop     (pop),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    rss_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .pop     (pop),
        .out_ch  (out_ch)
    );

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_valid)
        else $error("pop from empty queue");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
        else $error("result dropped");
endmodule
`default_nettype wire

FILE: test/rss_safety_supervisor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss safety supervisor testbench
// drives frames of begin, risk, merge and end transactions with bursty
// input and stalling output, predicts each decision and compares the whole
// result item; walks several register settings including the extremes
// ----------------------------------------------------------------------------
module rss_safety_supervisor_tb;
    import rss_pkg::*;

    localparam int F = 8;
    localparam int WATCHDOG = 20000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rss_in_if in_ch ();
    rss_out_if out_ch ();

    rss_safety_supervisor uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [15:0] p_cfg [7];
    logic [15:0] p_ego;
    logic [15:0] p_speed;
    int          p_accel;
    logic [1:0]  p_level;
    logic [2:0]  p_flags;
    logic [2:0]  p_reason;
    logic [7:0]  p_greason;
    logic [23:0] p_dist;
    bit          p_closed;
    logic [31:0] p_vetos;
    logic [31:0] p_interventions;

    in_item_t  pending_items [$];
    out_item_t expected_decisions [$];
    int errors;
    int decisions_seen;
    int frames_sent;
    int idle_cycles;
    bit stim_done;
    int burst_left;
    int gap_left;
    int stall_phase;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [15:0] sub_floor(input logic [15:0] v, input int dec,
                                              input int fl);
        if (int'(v) >= dec + fl)
            return 16'(int'(v) - dec);
        return fl[15:0];
    endfunction

    function automatic logic [23:0] rss_distance(input logic [15:0] v, input logic [15:0] l);
        longint unsigned t, a, b, lb, fl, rv, rd, eb, fb, pos, d;
        t = p_cfg[CFG_RESPONSE];
        a = p_cfg[CFG_MAX_ACCEL];
        b = p_cfg[CFG_COMFORT];
        lb = p_cfg[CFG_LEAD];
        fl = ((1 << F) + 5) / 10;
        if (b < fl)
            b = fl;
        if (lb < fl)
            lb = fl;
        rv = v + ((t * a) >> F);
        rd = ((v * t) >> F) + ((a * t * t) >> (2 * F + 1));
        eb = (rv * rv) / (2 * b);
        fb = (64'(l) * l) / (2 * lb);
        pos = rd + eb;
        d = (pos >= fb + 4 * (1 << F)) ? pos - fb : 4 * (1 << F);
        if (d > 24'hFFFFFF)
            d = 24'hFFFFFF;
        return d[23:0];
    endfunction

    function automatic int accel_sat(input int mag);
        return (mag > 2048) ? -2048 : -mag;
    endfunction

    task automatic predict_decision(input in_item_t it);
        out_item_t o;
        int up, m;
        if (it.operation == OP_BEGIN)
        begin
            p_ego = it.host_speed;
            p_speed = it.planned_speed;
            p_accel = 0;
            p_level = LVL_NONE;
            p_flags = 3'b000;
            p_reason = RSN_NONE;
            p_greason = it.gap_reason_code;
            p_closed = 0;
            p_dist = rss_distance(it.host_speed, it.lead_speed);
            if (it.lane_change_request && !it.gap_accepted)
            begin
                p_flags |= 3'b011;
                p_speed = (p_speed < sub_floor(it.host_speed, ((12 << F) + 5) / 10, 6 << F)) ?
                    p_speed : sub_floor(it.host_speed, ((12 << F) + 5) / 10, 6 << F);
                p_level = LVL_VETO;
                p_reason = RSN_GAP;
                p_vetos++;
                p_interventions++;
            end
            if (it.lead_gap < p_dist)
            begin
                up = int'(it.lead_speed) + (1 << (F - 1));
                if (up > 65535)
                    up = 65535;
                p_flags |= 3'b010;
                if (int'(p_speed) > up)
                    p_speed = up[15:0];
                p_accel = accel_sat(2 << F);
                if (p_level < LVL_CLAMP)
                    p_level = LVL_CLAMP;
                p_reason = RSN_RSS;
            end
            return;
        end
        if (p_closed)
            return;
        if (it.operation == OP_RISK)
        begin
            if (!p_flags[2] && it.event_flag && it.event_time < p_cfg[CFG_TTC])
            begin
                p_flags |= 3'b110;
                p_speed = 16'd0;
                p_accel = accel_sat(((48 << F) + 5) / 10);
                p_level = LVL_EMERG;
                p_reason = RSN_CRIT;
                p_interventions++;
            end
            return;
        end
        if (it.operation == OP_MERGE)
        begin
            if (!p_flags[2] && it.event_flag && it.event_time < p_cfg[CFG_MTIME]
                && it.merge_probability > p_cfg[CFG_MPROB][8:0])
            begin
                m = accel_sat(((28 << F) + 5) / 10);
                p_flags |= 3'b010;
                if (p_speed > sub_floor(p_ego, 3 << F, 4 << F))
                    p_speed = sub_floor(p_ego, 3 << F, 4 << F);
                if (m < p_accel)
                    p_accel = m;
                if (p_level < LVL_CLAMP)
                    p_level = LVL_CLAMP;
                p_reason = RSN_MERGE;
            end
            return;
        end
        if (!p_flags[2] && p_level != LVL_NONE)
            p_interventions++;
        p_closed = 1;
        o.speed_command = p_speed;
        o.accel_command = p_accel[11:0];
        o.action_level = p_level;
        o.lane_veto = p_flags[0];
        o.clamp_active = p_flags[1];
        o.hard_brake = p_flags[2];
        o.reason_code = p_reason;
        o.veto_reason = (p_reason == RSN_GAP) ? p_greason : 8'd0;
        o.safe_distance = p_dist;
        o.veto_total = p_vetos;
        o.intervention_total = p_interventions;
        expected_decisions.push_back(o);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predict_decision(in_ch.data);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.data <= pending_items.pop_front();
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(12, 1);
                        gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor and result side stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_phase <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            case ((stall_phase / 64) % 3)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(1, 0) == 1);
                default: out_ch.ready <= (stall_phase % 7) < 2;
            endcase
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_ch.valid && out_ch.ready)
            begin
                decisions_seen++;
                if (expected_decisions.size() == 0)
                begin
                    $display("%0t: unexpected decision %p", $time, out_ch.data);
                    errors++;
                end
                else if (expected_decisions[0] !== out_ch.data)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time,
                             expected_decisions[0], out_ch.data);
                    errors++;
                    void'(expected_decisions.pop_front());
                end
                else
                    void'(expected_decisions.pop_front());
            end
            if (idle_cycles >= WATCHDOG)
            begin
                $display("%0t: watchdog, no transaction for %0d cycles", $time, WATCHDOG);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic in_item_t random_item(input logic [1:0] op);
        in_item_t it;
        it.operation = op;
        it.host_speed = ($urandom_range(3, 0) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(12000, 0));
        it.lead_speed = ($urandom_range(3, 0) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(12000, 0));
        it.lead_gap = ($urandom_range(3, 0) == 0) ? 18'($urandom)
                                                  : 18'($urandom_range(40000, 0));
        it.planned_speed = 16'($urandom);
        it.lane_change_request = 1'($urandom);
        it.gap_accepted = 1'($urandom);
        it.gap_reason_code = 8'($urandom);
        it.event_flag = ($urandom_range(3, 0) != 0);
        it.event_time = ($urandom_range(1, 0) == 0) ? 16'($urandom_range(600, 0))
                                                    : 16'($urandom);
        it.merge_probability = 9'($urandom_range(256, 0));
        return it;
    endfunction

    task automatic queue_frame();
        int n;
        pending_items.push_back(random_item(OP_BEGIN));
        n = $urandom_range(5, 0);
        repeat (n)
            pending_items.push_back(random_item($urandom_range(1, 0) ? OP_RISK : OP_MERGE));
        pending_items.push_back(random_item(OP_END));
        frames_sent++;
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        p_cfg[idx] = (idx == CFG_MPROB) ? {7'd0, val[8:0]} : val;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || in_ch.valid || expected_decisions.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic directed_items();
        in_item_t it;
        it = '0;
        // items before any begin act on an open empty frame until the first end closes it
        it.operation = OP_RISK; it.event_flag = 1; it.event_time = 0;
        pending_items.push_back(it);
        it.operation = OP_END;
        pending_items.push_back(it);
        it.operation = OP_RISK;
        pending_items.push_back(it);
        it.operation = OP_END;
        pending_items.push_back(it);
        // all ones begin, lane veto, then merge
        it = '1;
        it.operation = OP_BEGIN; it.gap_accepted = 0;
        pending_items.push_back(it);
        it.operation = OP_MERGE; it.event_time = 0; it.merge_probability = 256;
        pending_items.push_back(it);
        it.operation = OP_END;
        pending_items.push_back(it);
        it = '0;
        it.operation = OP_BEGIN; it.host_speed = 2000; it.lead_gap = 0;
        it.lane_change_request = 1; it.gap_reason_code = 8'hA5;
        pending_items.push_back(it);
        it.operation = OP_RISK; it.event_flag = 1; it.event_time = 10;
        pending_items.push_back(it);
        it.operation = OP_MERGE; it.merge_probability = 256;
        pending_items.push_back(it);
        it.operation = OP_END;
        pending_items.push_back(it);
        it = '0;
        it.operation = OP_BEGIN; it.lead_gap = '1; it.planned_speed = 3000;
        it.host_speed = 500;
        pending_items.push_back(it);
        it.operation = OP_MERGE; it.event_flag = 1; it.event_time = 100;
        it.merge_probability = 200;
        pending_items.push_back(it);
        it.operation = OP_END;
        pending_items.push_back(it);
        it.operation = OP_END;
        pending_items.push_back(it);
    endtask

    initial
    begin
        logic [15:0] setting;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        decisions_seen = 0;
        frames_sent = 0;
        stim_done = 0;
        p_cfg[0] = 154; p_cfg[1] = 461; p_cfg[2] = 1152; p_cfg[3] = 1536;
        p_cfg[4] = 307; p_cfg[5] = 358; p_cfg[6] = 115;
        p_ego = 0; p_speed = 0; p_accel = 0; p_level = LVL_NONE; p_flags = 0;
        p_reason = RSN_NONE; p_greason = 0; p_dist = 0; p_closed = 0;
        p_vetos = 0; p_interventions = 0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        directed_items();
        drain();
        for (int phase = 0; phase < 5; phase++)
        begin
            for (int r = 0; r < 7; r++)
            begin
                case (phase)
                    0: setting = 16'd0;
                    1: setting = 16'hFFFF;
                    2: setting = (r == CFG_MPROB) ? 16'd256 : 16'd1;
                    default: setting = (r == CFG_MPROB) ? 16'($urandom_range(256, 0))
                                                        : 16'($urandom_range(2000, 20));
                endcase
                write_cfg(r[2:0], setting);
            end
            repeat (24)
                queue_frame();
            drain();
        end
        // back to the reset values for the last stretch
        write_cfg(CFG_RESPONSE, 16'd154); write_cfg(CFG_MAX_ACCEL, 16'd461);
        write_cfg(CFG_COMFORT, 16'd1152); write_cfg(CFG_LEAD, 16'd1536);
        write_cfg(CFG_TTC, 16'd307); write_cfg(CFG_MTIME, 16'd358);
        write_cfg(CFG_MPROB, 16'd115);
        repeat (16)
            queue_frame();
        drain();
        $display("covered %0d random frames over six register settings, %0d decisions checked",
                 frames_sent, decisions_seen);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
